[hdl/spectral_energy_onset_detector_defines.svh]
// Assertion macros shared by the checker of the onset detector.
`ifndef SPECTRAL_ENERGY_ONSET_DETECTOR_DEFINES_SVH
`define SPECTRAL_ENERGY_ONSET_DETECTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SEOD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("onset detector check failed");

// The consequent must hold in the cycle after the antecedent.
`define SEOD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("onset detector check failed");

`endif

[hdl/seod_pkg.sv]
// Package with widths, types and constant ROM tables of the onset detector.
package seod_pkg;

  localparam int unsigned BINS           = 512;
  localparam int unsigned COUNT_BITS     = 20;
  localparam int unsigned LOG_TABLE_BITS = 10;

  localparam int unsigned TAP_W    = $clog2(BINS);
  localparam int unsigned LOG_SH   = 16 - LOG_TABLE_BITS;
  localparam int unsigned LOG_SIZE = (1 << LOG_TABLE_BITS) + 1;
  localparam int unsigned LOG_AW   = LOG_TABLE_BITS + 1;

  localparam int unsigned X_W      = 16;
  localparam int unsigned WIN_W    = 17;
  localparam int unsigned LOG_W    = 17;
  localparam int unsigned E_W      = 25;
  localparam int unsigned SUM_W    = 45;
  localparam int unsigned CNT_W    = COUNT_BITS;
  localparam int unsigned RATIO_W  = 10;
  localparam int unsigned SIDE_W   = 16;
  localparam int unsigned JUMP_W   = 7;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned UK_W     = 33;
  localparam int unsigned LHS_W    = E_W + CNT_W + 1;
  localparam int unsigned RP_W     = RATIO_W + SUM_W;
  localparam int unsigned RHS_W    = RP_W + 1 - 8;
  localparam int unsigned CMP_W    = (LHS_W > RHS_W) ? LHS_W : RHS_W;
  localparam int unsigned SKP_W    = SIDE_W + E_W;
  localparam int unsigned UKP_W    = JUMP_W + E_W;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned RES_DEPTH   = 2;
  localparam int unsigned RES_PW      = $clog2(RES_DEPTH);
  localparam int unsigned RES_CW      = $clog2(RES_DEPTH + 1);

  localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(307);
  localparam logic [SIDE_W-1:0]  SIDE_RESET  = SIDE_W'(9830);
  localparam logic [JUMP_W-1:0]  JUMP_RESET  = JUMP_W'(10);

  localparam logic [E_W-1:0]   E_MAX   = {E_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    CFG_ONSET_RATIO = 2'd0,
    CFG_SIDE_GAIN   = 2'd1,
    CFG_JUMP_GAIN   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [RATIO_W-1:0] onset_ratio;
    logic [SIDE_W-1:0]  side_gain;
    logic [JUMP_W-1:0]  jump_gain;
  } cfg_t;

  typedef struct packed {
    logic [X_W-1:0]   bin_value;
    logic [TAP_W-1:0] tap;
    logic             last_bin;
    logic             song_start;
  } item_t;

  typedef struct packed {
    logic [E_W-1:0]         energy;
    logic                   onset;
    logic [E_W-1:0]         side_kick;
    logic signed [UK_W-1:0] up_kick;
  } res_t;

  typedef logic [WIN_W-1:0] win_rom_t [BINS];
  typedef logic [LOG_W-1:0] log_rom_t [LOG_SIZE];

  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] WIN_DEN = 64'(2 * BINS);

  // Q24 base-2 logarithm by repeated squaring of the mantissa.
  function automatic logic [63:0] lg2_q24(input logic [63:0] n);
    logic [63:0] m;
    logic [63:0] r;
    int          e;
    e = 0;
    for (int b = 1; b <= 40; b++) begin
      if ((n >> b) != 64'd0) e = b;
    end
    if (n == 64'd0) return 64'd0;
    m = (n << 30) >> e;
    r = 64'(e) << 24;
    for (int b = 23; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        r[b] = 1'b1;
      end
    end
    return r;
  endfunction

  localparam logic [63:0] LOG101_Q24  = lg2_q24(64'd101);
  localparam logic [63:0] LOG101_HALF = LOG101_Q24 / 2;

  function automatic logic [63:0] hann_next(input logic [63:0] s);
    return (s >= ONE_Q30) ? 64'd0 : ONE_Q30 - s;
  endfunction

  // Half-Hann taper: cosine built from a nested Taylor series in Q30.
  function automatic win_rom_t build_win();
    win_rom_t    t;
    logic [63:0] theta;
    logic [63:0] t2;
    logic [63:0] f;
    for (int i = 0; i < BINS; i++) begin
      theta = (PI_Q30 * 64'(i)) / WIN_DEN;
      t2    = (theta * theta) >> 30;
      f     = ONE_Q30;
      f     = hann_next(((t2 * f) >> 30) / 132);
      f     = hann_next(((t2 * f) >> 30) / 90);
      f     = hann_next(((t2 * f) >> 30) / 56);
      f     = hann_next(((t2 * f) >> 30) / 30);
      f     = hann_next(((t2 * f) >> 30) / 12);
      f     = hann_next(((t2 * f) >> 30) / 2);
      t[i]  = WIN_W'((f * f + (64'd1 << 43)) >> 44);
    end
    return t;
  endfunction

  // Compression curve log(1+100y)/log(101) in Q1.16 at the table knots.
  function automatic log_rom_t build_log();
    log_rom_t    t;
    logic [63:0] num;
    for (int k = 0; k < LOG_SIZE; k++) begin
      num  = lg2_q24((64'd1 << LOG_TABLE_BITS) + 64'd100 * 64'(k))
             - (64'(LOG_TABLE_BITS) << 24);
      t[k] = LOG_W'(((num << 16) + LOG101_HALF) / LOG101_Q24);
    end
    return t;
  endfunction

  localparam win_rom_t WIN_ROM = build_win();
  localparam log_rom_t LOG_ROM = build_log();

endpackage

[hdl/spectral_energy_onset_detector.sv]
// Top level of the spectral energy onset detector.
//
//   channel   direction  handshake          payload
//   bins      in         push / full        bin_value_i, last_bin_i, song_start_i
//   results   out        pop / empty        frame_energy_out_o, onset_o, side_kick_o,
//                                           up_kick_o
//   config    in         cfg_we_i           cfg_idx_i, cfg_data_i
//
// One bin is taken every cycle while the four-entry bin queue has room; the
// back-end pipeline moves one bin per cycle through its six register stages
// while the result queue has room. A frame's result enters the result queue as
// its last bin leaves the sixth stage, and reaches the result ports from there.
// Reset clears the tap counter, the sums, the frame count and both queues; the
// window and log tables are constant, so no clearing pass is needed.
// A full two-entry result queue halts the back end, and the bin queue then
// fills and raises full.
module spectral_energy_onset_detector (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic [seod_pkg::X_W-1:0]           bin_value_i,
  input  logic                               last_bin_i,
  input  logic                               song_start_i,
  output logic                               empty,
  input  logic                               pop,
  output logic [seod_pkg::E_W-1:0]           frame_energy_out_o,
  output logic                               onset_o,
  output logic [seod_pkg::E_W-1:0]           side_kick_o,
  output logic signed [seod_pkg::UK_W-1:0]   up_kick_o,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [seod_pkg::CFG_W-1:0]         cfg_data_i
);
  import seod_pkg::*;

  cfg_t  cfg_q;
  item_t front_item;
  item_t q_head;
  logic  front_push;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;
  res_t  res_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.onset_ratio <= RATIO_RESET;
      cfg_q.side_gain   <= SIDE_RESET;
      cfg_q.jump_gain   <= JUMP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ONSET_RATIO: cfg_q.onset_ratio <= cfg_data_i[RATIO_W-1:0];
        CFG_SIDE_GAIN:   cfg_q.side_gain   <= cfg_data_i[SIDE_W-1:0];
        CFG_JUMP_GAIN:   cfg_q.jump_gain   <= cfg_data_i[JUMP_W-1:0];
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

  seod_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .bin_value_i  (bin_value_i),
    .last_bin_i   (last_bin_i),
    .song_start_i (song_start_i),
    .q_full_i     (q_full),
    .q_push_o     (front_push),
    .q_item_o     (front_item)
  );

  seod_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  seod_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_item_i    (q_head),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .cfg_i       (cfg_q),
    .res_pop_i   (pop),
    .res_empty_o (empty),
    .res_head_o  (res_head)
  );

  assign full               = q_full;
  assign frame_energy_out_o = res_head.energy;
  assign onset_o            = res_head.onset;
  assign side_kick_o        = res_head.side_kick;
  assign up_kick_o          = res_head.up_kick;

endmodule

[hdl/seod_front.sv]
// Front end: accepts bins, tracks the window tap and tags each bin for the back end.
module seod_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic [seod_pkg::X_W-1:0]  bin_value_i,
  input  logic                      last_bin_i,
  input  logic                      song_start_i,
  input  logic                      q_full_i,
  output logic                      q_push_o,
  output seod_pkg::item_t           q_item_o
);
  import seod_pkg::*;

  localparam logic [TAP_W-1:0] TAP_MAX = TAP_W'(BINS - 1);

  logic [TAP_W-1:0] bin_index_q, bin_index_d;
  logic             accept;

  assign accept = push_i & ~q_full_i;

  always_comb begin
    bin_index_d = bin_index_q;
    if (accept) begin
      if (last_bin_i) begin
        bin_index_d = '0;
      end else if (bin_index_q != TAP_MAX) begin
        bin_index_d = bin_index_q + TAP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_index_q <= '0;
    end else begin
      bin_index_q <= bin_index_d;
    end
  end

  assign q_push_o            = accept;
  assign q_item_o.bin_value  = bin_value_i;
  assign q_item_o.tap        = bin_index_q;
  assign q_item_o.last_bin   = last_bin_i;
  assign q_item_o.song_start = song_start_i;

endmodule

[hdl/seod_queue.sv]
// Short bin queue that decouples the front end from the back-end pipeline.
module seod_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  seod_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output seod_pkg::item_t head_o
);
  import seod_pkg::*;

  item_t               mem_q [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CW-1:0] count_q, count_d;
  logic                do_push;
  logic                do_pop;

  assign full_o  = (count_q == QUEUE_CW'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QUEUE_PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QUEUE_PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + QUEUE_CW'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - QUEUE_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[hdl/seod_back.sv]
// Back end: taper, log compression, frame accumulation, onset test and result queue.
module seod_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  seod_pkg::item_t q_item_i,
  input  logic            q_empty_i,
  output logic            q_pop_o,
  input  seod_pkg::cfg_t  cfg_i,
  input  logic            res_pop_i,
  output logic            res_empty_o,
  output seod_pkg::res_t  res_head_o
);
  import seod_pkg::*;

  // Stage valid bits and the shared advance strobe.
  logic adv;
  logic take;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;

  // Stage 1: bin and window tap.
  logic [X_W-1:0]   x1_q;
  logic [WIN_W-1:0] w1_q;
  logic             last1_q, start1_q;
  // Stage 2: weighted bin.
  logic [X_W+WIN_W-1:0] wprod;
  logic [X_W-1:0]       y2_q;
  logic                 last2_q, start2_q;
  // Stage 3: neighboring knots of the log table.
  logic [LOG_TABLE_BITS-1:0] idx2;
  logic [LOG_W-1:0]          lo3_q, hi3_q;
  logic [LOG_SH-1:0]         fr3_q;
  logic                      last3_q, start3_q;
  // Stage 4: interpolated compressed value.
  logic [LOG_W-1:0]        diff3;
  logic [LOG_W+LOG_SH-1:0] dprod3;
  logic [LOG_W-1:0]        cval3;
  logic [LOG_W-1:0]        cval4_q;
  logic                    last4_q, start4_q;
  // Stage 5: frame and song accumulators.
  logic [E_W-1:0]   energy_q, energy_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [E_W:0]     e_add;
  logic [E_W-1:0]   e_sat;
  logic [SUM_W-1:0] sum_base;
  logic [CNT_W-1:0] cnt_base;
  logic [SUM_W:0]   sum_add;
  logic [SUM_W-1:0] sum_sat;
  logic [E_W-1:0]   e5_q;
  logic [SUM_W-1:0] sum5_q;
  logic [CNT_W-1:0] cnt5_q;
  // Stage 6: products.
  logic [LHS_W-1:0] lhs6_q;
  logic [RP_W-1:0]  rp6_q;
  logic [SKP_W-1:0] skp6_q;
  logic [UKP_W-1:0] ukp6_q;
  logic [E_W-1:0]   e6_q;
  // Result assembly and result queue.
  logic [RP_W:0]    rp_round;
  logic [RHS_W-1:0] rhs;
  res_t             res_new;
  res_t             res_mem_q [RES_DEPTH];
  logic [RES_PW-1:0] res_wr_q, res_rd_q;
  logic [RES_CW-1:0] res_cnt_q, res_cnt_d;
  logic              res_push;
  logic              res_take;

  // The whole pipeline holds while the result queue is full.
  assign adv     = (res_cnt_q != RES_CW'(RES_DEPTH));
  assign take    = adv & ~q_empty_i;
  assign q_pop_o = take;

  assign wprod = (X_W+WIN_W)'(x1_q) * (X_W+WIN_W)'(w1_q);
  assign idx2  = y2_q[X_W-1:LOG_SH];

  assign diff3  = (hi3_q >= lo3_q) ? hi3_q - lo3_q : '0;
  assign dprod3 = (LOG_W+LOG_SH)'(diff3) * (LOG_W+LOG_SH)'(fr3_q);
  assign cval3  = lo3_q + LOG_W'(dprod3 >> LOG_SH);

  always_comb begin
    e_add    = {1'b0, energy_q} + (E_W+1)'(cval4_q);
    e_sat    = e_add[E_W] ? E_MAX : e_add[E_W-1:0];
    sum_base = start4_q ? '0 : sum_q;
    cnt_base = start4_q ? '0 : cnt_q;
    sum_add  = {1'b0, sum_base} + (SUM_W+1)'(e_sat);
    sum_sat  = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
    energy_d = energy_q;
    sum_d    = sum_q;
    cnt_d    = cnt_q;
    if (adv && v4_q) begin
      if (last4_q) begin
        energy_d = '0;
        sum_d    = sum_sat;
        cnt_d    = (cnt_base == CNT_MAX) ? cnt_base : cnt_base + CNT_W'(1);
      end else begin
        energy_d = e_sat;
        sum_d    = sum_base;
        cnt_d    = cnt_base;
      end
    end
  end

  // Onset: E*(n+1) against ceil(ratio*sum/256); the kicks are scaled energies.
  always_comb begin
    rp_round          = {1'b0, rp6_q} + (RP_W+1)'(255);
    rhs               = rp_round[RP_W:8];
    res_new.energy    = e6_q;
    res_new.onset     = (CMP_W'(lhs6_q) >= CMP_W'(rhs));
    res_new.side_kick = skp6_q[SIDE_W +: E_W];
    res_new.up_kick   = UK_W'(0) - UK_W'(ukp6_q);
  end

  assign res_push    = adv & v6_q;
  assign res_take    = res_pop_i & ~res_empty_o;
  assign res_empty_o = (res_cnt_q == '0);
  assign res_head_o  = res_mem_q[res_rd_q];

  always_comb begin
    res_cnt_d = res_cnt_q;
    if (res_push && !res_take) begin
      res_cnt_d = res_cnt_q + RES_CW'(1);
    end else if (!res_push && res_take) begin
      res_cnt_d = res_cnt_q - RES_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      v5_q      <= 1'b0;
      v6_q      <= 1'b0;
      energy_q  <= '0;
      sum_q     <= '0;
      cnt_q     <= '0;
      res_wr_q  <= '0;
      res_rd_q  <= '0;
      res_cnt_q <= '0;
    end else begin
      if (adv) begin
        v1_q <= take;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q;
        v5_q <= v4_q & last4_q;
        v6_q <= v5_q;
      end
      energy_q <= energy_d;
      sum_q    <= sum_d;
      cnt_q    <= cnt_d;
      if (res_push) begin
        res_wr_q <= (res_wr_q == RES_PW'(RES_DEPTH - 1)) ? '0 : res_wr_q + RES_PW'(1);
      end
      if (res_take) begin
        res_rd_q <= (res_rd_q == RES_PW'(RES_DEPTH - 1)) ? '0 : res_rd_q + RES_PW'(1);
      end
      res_cnt_q <= res_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x1_q     <= q_item_i.bin_value;
      w1_q     <= WIN_ROM[q_item_i.tap];
      last1_q  <= q_item_i.last_bin;
      start1_q <= q_item_i.song_start;

      y2_q     <= wprod[16 +: X_W];
      last2_q  <= last1_q;
      start2_q <= start1_q;

      lo3_q    <= LOG_ROM[{1'b0, idx2}];
      hi3_q    <= LOG_ROM[LOG_AW'(idx2) + LOG_AW'(1)];
      fr3_q    <= y2_q[LOG_SH-1:0];
      last3_q  <= last2_q;
      start3_q <= start2_q;

      cval4_q  <= cval3;
      last4_q  <= last3_q;
      start4_q <= start3_q;

      e5_q     <= e_sat;
      sum5_q   <= sum_sat;
      cnt5_q   <= cnt_base;

      lhs6_q   <= LHS_W'(e5_q) * LHS_W'((CNT_W+1)'(cnt5_q) + (CNT_W+1)'(1));
      rp6_q    <= RP_W'(cfg_i.onset_ratio) * RP_W'(sum5_q);
      skp6_q   <= SKP_W'(cfg_i.side_gain) * SKP_W'(e5_q);
      ukp6_q   <= UKP_W'(cfg_i.jump_gain) * UKP_W'(e5_q);
      e6_q     <= e5_q;
    end
    if (res_push) begin
      res_mem_q[res_wr_q] <= res_new;
    end
  end

endmodule

[hdl/seod_checker.sv]
// Port-level checker for the onset detector and its bind to the top level.
`include "spectral_energy_onset_detector_defines.svh"

module seod_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               push,
  input logic                               full,
  input logic [seod_pkg::X_W-1:0]           bin_value_i,
  input logic                               last_bin_i,
  input logic                               song_start_i,
  input logic                               empty,
  input logic                               pop,
  input logic [seod_pkg::E_W-1:0]           frame_energy_out_o,
  input logic                               onset_o,
  input logic [seod_pkg::E_W-1:0]           side_kick_o,
  input logic signed [seod_pkg::UK_W-1:0]   up_kick_o,
  input logic                               cfg_we_i,
  input logic [1:0]                         cfg_idx_i,
  input logic [seod_pkg::CFG_W-1:0]         cfg_data_i
);
  import seod_pkg::*;

  // A waiting result stays until its transaction completes.
  `SEOD_ASSERT_NEXT(a_result_held, !empty && !pop, !empty)
  `SEOD_ASSERT_NEXT(a_result_stable, !empty && !pop,
                    $stable(frame_energy_out_o) && $stable(onset_o) && $stable(up_kick_o))
  // The side gain is below one, so the side kick never exceeds the energy.
  `SEOD_ASSERT_SAME(a_side_below_energy, !empty, side_kick_o <= frame_energy_out_o)
  // The vertical kick is a negated product and is never positive.
  `SEOD_ASSERT_SAME(a_up_not_positive, !empty, up_kick_o[UK_W-1] || (up_kick_o == '0))

endmodule

bind spectral_energy_onset_detector seod_checker u_checker (.*);

[test/onset_checker.sv]
`timescale 1ns / 100ps
// Checker that watches the onset detector's channels, predicts each frame result and compares it.
module onset_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  logic                             full_i,
  input  logic [seod_pkg::X_W-1:0]         bin_value_i,
  input  logic                             last_bin_i,
  input  logic                             song_start_i,
  input  logic                             empty_i,
  input  logic                             pop_i,
  input  logic [seod_pkg::E_W-1:0]         frame_energy_i,
  input  logic                             onset_i,
  input  logic [seod_pkg::E_W-1:0]         side_kick_i,
  input  logic [seod_pkg::UK_W-1:0]        up_kick_i,
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_idx_i,
  input  logic [seod_pkg::CFG_W-1:0]       cfg_data_i,
  output int                               error_count_o,
  output int                               pending_o,
  output int                               result_count_o,
  output int                               onset_count_o
);
  import seod_pkg::*;

  logic [WIN_W-1:0]   taper [BINS];
  logic [LOG_W-1:0]   knot [LOG_SIZE];

  logic [RATIO_W-1:0] ratio;
  logic [SIDE_W-1:0]  side;
  logic [JUMP_W-1:0]  jump;

  int unsigned        tap;
  logic [63:0]        energy;
  logic [63:0]        run_sum;
  logic [63:0]        frame_num;
  res_t               frames_due [$];
  int                 mismatches;
  int                 results_seen;
  int                 onsets_seen;

  function automatic logic [63:0] log2_q24(input logic [63:0] n);
    logic [63:0] mant;
    logic [63:0] acc;
    int          ex;
    if (n == 64'd0) return 64'd0;
    ex = 40;
    while (ex > 0 && (n >> ex) == 64'd0) ex--;
    mant = (n << 30) >> ex;
    acc  = 64'(ex) << 24;
    // Each squaring of the mantissa yields one more fraction bit.
    for (int b = 23; b >= 0; b--) begin
      mant = (mant * mant) >> 30;
      if (mant >= (64'd1 << 31)) begin
        mant   = mant >> 1;
        acc[b] = 1'b1;
      end
    end
    return acc;
  endfunction

  function automatic logic [WIN_W-1:0] taper_at(input int unsigned i);
    logic [63:0] theta;
    logic [63:0] t2;
    logic [63:0] f;
    logic [63:0] s;
    int unsigned divs [6];
    divs  = '{132, 90, 56, 30, 12, 2};
    theta = (PI_Q30 * 64'(i)) / 64'(2 * BINS);
    t2    = (theta * theta) >> 30;
    f     = ONE_Q30;
    foreach (divs[j]) begin
      s = ((t2 * f) >> 30) / 64'(divs[j]);
      f = (s >= ONE_Q30) ? 64'd0 : ONE_Q30 - s;
    end
    return WIN_W'((f * f + (64'd1 << 43)) >> 44);
  endfunction

  function automatic logic [LOG_W-1:0] knot_at(input int unsigned k);
    logic [63:0] num;
    logic [63:0] den;
    den = log2_q24(64'd101);
    num = log2_q24((64'd1 << LOG_TABLE_BITS) + 64'd100 * 64'(k))
          - (64'(LOG_TABLE_BITS) << 24);
    return LOG_W'(((num << 16) + den / 2) / den);
  endfunction

  initial begin
    for (int i = 0; i < BINS; i++) taper[i] = taper_at(i);
    for (int k = 0; k < LOG_SIZE; k++) knot[k] = knot_at(k);
  end

  task automatic accumulate_bin(input logic [X_W-1:0] v, input logic last,
                                input logic start);
    logic [63:0] y;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] lhs;
    logic [63:0] rhs;
    logic [63:0] sk;
    logic [63:0] uk;
    logic [63:0] neg;
    int unsigned sel;
    res_t        r;
    if (start) begin
      run_sum   = 64'd0;
      frame_num = 64'd0;
    end
    y   = (64'(v) * 64'(taper[tap])) >> 16;
    sel = 32'((y >> LOG_SH) & ((64'd1 << LOG_TABLE_BITS) - 64'd1));
    lo  = 64'(knot[sel]);
    hi  = 64'(knot[sel + 1]);
    energy = energy + lo
             + ((((hi >= lo) ? hi - lo : 64'd0) * (y & ((64'd1 << LOG_SH) - 64'd1)))
                >> LOG_SH);
    if (energy > 64'(E_MAX)) energy = 64'(E_MAX);
    if (!last) begin
      // An overlong frame keeps reusing the final window tap.
      if (tap < BINS - 1) tap++;
    end else begin
      run_sum = run_sum + energy;
      if (run_sum > 64'(SUM_MAX)) run_sum = 64'(SUM_MAX);
      lhs = energy * (frame_num + 64'd1);
      rhs = (64'(ratio) * run_sum + 64'd255) >> 8;
      sk  = (64'(side) * energy) >> 16;
      if (sk > 64'(E_MAX)) sk = 64'(E_MAX);
      uk  = 64'(jump) * energy;
      if (uk > (64'd1 << 32)) uk = 64'd1 << 32;
      neg = 64'd0 - uk;
      r.energy    = energy[E_W-1:0];
      r.onset     = (lhs >= rhs);
      r.side_kick = sk[E_W-1:0];
      r.up_kick   = neg[UK_W-1:0];
      frames_due = {frames_due, r};
      if (frame_num < 64'(CNT_MAX)) frame_num++;
      energy = 64'd0;
      tap    = 0;
    end
  endtask

  task automatic check_field(input string name, input logic [UK_W-1:0] want,
                             input logic [UK_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: frame %0d %s expected %0h actual %0h", $time, results_seen, name,
               want, got);
    end
  endtask

  task automatic compare_frame();
    res_t want;
    if (frames_due.size() == 0) begin
      mismatches++;
      $display("%0t: frame result expected none actual energy %0h onset %0b side %0h up %0h",
               $time, frame_energy_i, onset_i, side_kick_i, up_kick_i);
    end else begin
      want = frames_due.pop_front();
      check_field("frame energy", UK_W'(want.energy), UK_W'(frame_energy_i));
      check_field("onset", UK_W'(want.onset), UK_W'(onset_i));
      check_field("side kick", UK_W'(want.side_kick), UK_W'(side_kick_i));
      check_field("up kick", want.up_kick, up_kick_i);
      results_seen++;
      if (want.onset) onsets_seen++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio     = RATIO_RESET;
      side      = SIDE_RESET;
      jump      = JUMP_RESET;
      tap       = 0;
      energy    = 64'd0;
      run_sum   = 64'd0;
      frame_num = 64'd0;
      frames_due.delete();
      mismatches   = 0;
      results_seen = 0;
      onsets_seen  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ONSET_RATIO: ratio = cfg_data_i[RATIO_W-1:0];
          CFG_SIDE_GAIN:   side  = cfg_data_i[SIDE_W-1:0];
          CFG_JUMP_GAIN:   jump  = cfg_data_i[JUMP_W-1:0];
          default: ;
        endcase
      end
      if (pop_i && !empty_i) compare_frame();
      if (push_i && !full_i) accumulate_bin(bin_value_i, last_bin_i, song_start_i);
    end
    // Counters reach the stimulus side through nonblocking assignments, free of ordering races.
    error_count_o  <= mismatches;
    pending_o      <= frames_due.size();
    result_count_o <= results_seen;
    onset_count_o  <= onsets_seen;
  end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// Testbench top of the spectral energy onset detector: stimulus, watchdog and verdict.
module tb;
  import seod_pkg::*;

  typedef enum int {
    LVL_ANY,
    LVL_LOW,
    LVL_MAX,
    LVL_ZERO,
    LVL_HIGH
  } level_e;

  localparam logic [1:0] CFG_UNUSED_IDX   = 2'd3;
  localparam int         PHASES           = 6;
  localparam int         ITEMS_PER_PHASE  = 137;
  localparam int         SETTLE_CYCLES    = 16;
  localparam int         STALL_LIMIT      = 4000;

  logic               clk_i;
  logic               rst_ni       = 1'b0;
  logic               push         = 1'b0;
  logic               full;
  logic [X_W-1:0]     bin_value_i  = '0;
  logic               last_bin_i   = 1'b0;
  logic               song_start_i = 1'b0;
  logic               empty;
  logic               pop          = 1'b0;
  logic [E_W-1:0]     frame_energy_out_o;
  logic               onset_o;
  logic [E_W-1:0]     side_kick_o;
  logic [UK_W-1:0]    up_kick_o;
  logic               cfg_we_i     = 1'b0;
  logic [1:0]         cfg_idx_i    = CFG_ONSET_RATIO;
  logic [CFG_W-1:0]   cfg_data_i   = '0;

  int                 error_count;
  int                 pending;
  int                 result_count;
  int                 onset_count;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  int                 bins_sent     = 0;
  int                 settings      = 1;
  int                 stall_cycles  = 0;

  spectral_energy_onset_detector uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .bin_value_i        (bin_value_i),
    .last_bin_i         (last_bin_i),
    .song_start_i       (song_start_i),
    .empty              (empty),
    .pop                (pop),
    .frame_energy_out_o (frame_energy_out_o),
    .onset_o            (onset_o),
    .side_kick_o        (side_kick_o),
    .up_kick_o          (up_kick_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i)
  );

  onset_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_i         (full),
    .bin_value_i    (bin_value_i),
    .last_bin_i     (last_bin_i),
    .song_start_i   (song_start_i),
    .empty_i        (empty),
    .pop_i          (pop),
    .frame_energy_i (frame_energy_out_o),
    .onset_i        (onset_o),
    .side_kick_i    (side_kick_o),
    .up_kick_i      (up_kick_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .error_count_o  (error_count),
    .pending_o      (pending),
    .result_count_o (result_count),
    .onset_count_o  (onset_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    pop <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL spectral_energy_onset_detector");
        $finish;
      end
    end
  end

  // Push stays high from one transaction to the next unless an idle cycle is drawn.
  task automatic send_bin(input logic [X_W-1:0] v, input logic last, input logic start);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push         <= 1'b1;
    bin_value_i  <= v;
    last_bin_i   <= last;
    song_start_i <= start;
    do @(posedge clk_i); while (full);
    bins_sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value,
                           input int width);
    logic [CFG_W-1:0] keep;
    keep = CFG_W'((32'd1 << width) - 1);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= (CFG_W'($urandom) & ~keep) | (value & keep);
    @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] s,
                               input logic [CFG_W-1:0] j);
    write_reg(CFG_ONSET_RATIO, r, RATIO_W);
    write_reg(CFG_SIDE_GAIN, s, SIDE_W);
    write_reg(CFG_JUMP_GAIN, j, JUMP_W);
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  function automatic logic [X_W-1:0] pick_value(input level_e level);
    if ($urandom_range(0, 99) < 10) return X_W'($urandom);
    case (level)
      LVL_LOW:  return X_W'($urandom_range(0, 255));
      LVL_MAX:  return '1;
      LVL_ZERO: return '0;
      LVL_HIGH: return X_W'($urandom) | (X_W'(1) << (X_W - 1));
      default:  return X_W'($urandom);
    endcase
  endfunction

  function automatic int frame_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) return $urandom_range(1, 32);
    if (pick < 92) return $urandom_range(BINS - 3, BINS);
    if (pick < 96) return $urandom_range(BINS + 1, BINS + 24);
    return $urandom_range(33, 200);
  endfunction

  task automatic send_frame(input int len, input level_e level);
    for (int j = 0; j < len; j++) begin
      send_bin(pick_value(level), (j == len - 1), ($urandom_range(0, 99) < 3));
    end
  endtask

  initial begin : stimulus
    int phase_base;
    int len;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 13;
    recv_idle_pct = 48;
    // Directed frames under the reset register values.
    send_bin('0, 1'b1, 1'b0);
    send_bin('1, 1'b1, 1'b0);
    send_bin(16'h8000, 1'b0, 1'b1);
    send_bin(16'h0001, 1'b0, 1'b0);
    send_bin('1, 1'b1, 1'b0);
    send_bin(16'hAAAA, 1'b0, 1'b0);
    send_bin(16'h5555, 1'b1, 1'b1);
    // A song start in mid-frame clears the sums but keeps the partial energy.
    send_bin(16'h1234, 1'b0, 1'b0);
    send_bin(16'hFEDC, 1'b0, 1'b1);
    send_bin('1, 1'b1, 1'b0);
    send_frame(BINS, LVL_MAX);
    send_frame(BINS + 40, LVL_MAX);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p / 2)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 48;
        end
        1: begin
          send_idle_pct = 48;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (p)
        0: apply_setting('0, '0, '0);
        1: apply_setting(CFG_W'(1023), CFG_W'(65535), CFG_W'(127));
        2: apply_setting(CFG_W'(RATIO_RESET), CFG_W'(SIDE_RESET), CFG_W'(JUMP_RESET));
        default: apply_setting(CFG_W'($urandom_range(0, 1023)), CFG_W'($urandom),
                               CFG_W'($urandom_range(0, 100)));
      endcase
      if (p == 3) begin
        // A write to the unused index must leave every register alone.
        write_reg(CFG_UNUSED_IDX, CFG_W'($urandom), CFG_W);
        cfg_we_i <= 1'b0;
      end
      phase_base = bins_sent;
      while (bins_sent - phase_base < ITEMS_PER_PHASE) begin
        // A frame that would run past the bin budget of the phase is cut short.
        len = frame_length();
        if (len > ITEMS_PER_PHASE - (bins_sent - phase_base)) begin
          len = ITEMS_PER_PHASE - (bins_sent - phase_base);
        end
        send_frame(len, level_e'($urandom_range(0, 4)));
        if ($urandom_range(0, 99) < 3) drain();
      end
      drain();
    end

    $display("Run covered %0d bins and %0d checked frame results with %0d onsets,",
             bins_sent, result_count, onset_count);
    $display("under %0d register settings and three sender/receiver idle mixes.",
             settings);
    if (error_count == 0 && pending == 0) begin
      $display("PASS spectral_energy_onset_detector");
    end else begin
      $display("FAIL spectral_energy_onset_detector");
    end
    $finish;
  end

endmodule
